### rtl/ofrs_pkg.sv
// ----------------------------------------------------------------------------
// ofrs_pkg
// Shared types and codes of the display frame refresh sequencer.
// ----------------------------------------------------------------------------
package ofrs_pkg;

    // request codes
    localparam logic [2:0] REQ_DRAW   = 3'd0;
    localparam logic [2:0] REQ_CLEAR  = 3'd1;
    localparam logic [2:0] REQ_UPDATE = 3'd2;
    localparam logic [2:0] REQ_DONE   = 3'd3;
    localparam logic [2:0] REQ_ERROR  = 3'd4;
    localparam logic [2:0] REQ_READ   = 3'd5;

    // transfer constants
    localparam logic [7:0] LEAD_CMD      = 8'h00;
    localparam logic [7:0] LEAD_DATA     = 8'h40;
    localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [7:0] CMD_LEN       = 8'd4;
    localparam logic       KIND_CMD      = 1'b0;
    localparam logic       KIND_DATA     = 1'b1;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       pixel_on;
        logic [9:0] read_index;
    } item_t;

    typedef struct packed {
        logic       start_transfer;
        logic       transfer_kind;
        logic [2:0] transfer_page;
        logic [7:0] transfer_length;
        logic [7:0] lead_byte;
        logic [7:0] page_command;
        logic [7:0] read_data;
        logic       busy_res;
        logic       available;
        logic       pending;
    } res_t;

    // description of a started bus transfer
    typedef struct packed {
        logic       start;
        logic       kind;
        logic [2:0] page;
        logic [7:0] length;
        logic [7:0] lead;
        logic [7:0] cmd;
    } xfer_t;

    typedef enum logic [1:0] {
        SW_CLEAR_DRAW = 2'd0,
        SW_COPY       = 2'd1,
        SW_CLEAR_ALL  = 2'd2
    } sweep_mode_t;

    // control from the item logic to the stores
    typedef struct packed {
        logic        rd_draw;
        logic        rd_frame;
        logic        wr_draw;
        logic        sweep_start;
        sweep_mode_t sweep_mode;
    } store_ctl_t;

    function automatic xfer_t make_xfer(logic kind, logic [7:0] page8, logic [7:0] data_len);
        xfer_t x;
        x.start  = 1'b1;
        x.kind   = kind;
        x.page   = page8[2:0];
        x.length = (kind == KIND_DATA) ? data_len : CMD_LEN;
        x.lead   = (kind == KIND_DATA) ? LEAD_DATA : LEAD_CMD;
        x.cmd    = PAGE_CMD_BASE + page8;
        return x;
    endfunction

endpackage

### rtl/oled_frame_refresh_sequencer.sv
// ----------------------------------------------------------------------------
// oled_frame_refresh_sequencer
// Page-mode framebuffer with a refresh sequencer: pixel draw and clear into
// a draw store, snapshot into a frame store, page transfer ordering.
//
//   channel | ports                      | moves
//   --------+----------------------------+-------------------------------
//   input   | s_valid, s_ready, s_data   | one request per transfer
//   result  | m_valid, m_ready, m_data   | one result per request
//
// Draw, read, update-while-busy and transfer events are accepted with the
// store reads, then modified and written back. Clear and a frame snapshot
// sweep the store a byte a cycle. After reset a clearing pass runs before
// the first request is taken. A result held by m_ready waits in the output
// register while the next request is accepted and worked on.
// ----------------------------------------------------------------------------
module oled_frame_refresh_sequencer #(
    parameter int unsigned COLUMNS = 128,
    parameter int unsigned PAGES   = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ofrs_pkg::item_t s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output ofrs_pkg::res_t  m_data
);

    localparam int unsigned N  = COLUMNS * PAGES;
    localparam int unsigned AW = $clog2(N);
    localparam logic [AW-1:0] COL_A = AW'(COLUMNS);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    ofrs_pkg::item_t      item_reg;
    logic [AW-1:0]        pix_addr_reg;
    logic                 pix_ok_reg;
    logic                 rd_ok_reg;
    ofrs_pkg::res_t       res_reg, res_c;
    ofrs_pkg::res_t       m_data_reg;
    logic                 m_valid_reg, m_valid_next;

    logic                 accept, out_free, load_out, in_exec, need_sweep;
    logic [AW-1:0]        pix_addr_c;
    logic                 pix_ok_c, rd_ok_c;
    logic [7:0]           pix_mask, draw_rd_data, frame_rd_data, draw_wr_data;
    ofrs_pkg::store_ctl_t ctl;
    logic                 sweep_done;
    ofrs_pkg::xfer_t      xfer;
    logic                 snap, busy_n, avail_n, pend_n;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_exec  = (state_reg == ST_EXEC);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // address decode of the incoming request
    assign pix_ok_c = (32'(s_data.pixel_x) < COLUMNS) && (32'(s_data.pixel_y) < 8 * PAGES);
    assign rd_ok_c  = (32'(s_data.read_index) < N);
    assign pix_addr_c = AW'(s_data.pixel_x) + AW'(AW'(s_data.pixel_y[7:3]) * COL_A);

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg     <= s_data;
            pix_addr_reg <= pix_addr_c;
            pix_ok_reg   <= pix_ok_c;
            rd_ok_reg    <= rd_ok_c;
        end
    end

    // pixel read-modify-write
    assign pix_mask     = 8'(1) << item_reg.pixel_y[2:0];
    assign draw_wr_data = item_reg.pixel_on ? (draw_rd_data | pix_mask)
                                            : (draw_rd_data & ~pix_mask);

    assign need_sweep = in_exec && ((item_reg.req_type == ofrs_pkg::REQ_CLEAR) || snap);

    always_comb begin
        ctl.rd_draw     = accept;
        ctl.rd_frame    = accept;
        ctl.wr_draw     = in_exec && pix_ok_reg && (item_reg.req_type == ofrs_pkg::REQ_DRAW);
        ctl.sweep_start = need_sweep;
        ctl.sweep_mode  = (item_reg.req_type == ofrs_pkg::REQ_CLEAR) ?
                          ofrs_pkg::SW_CLEAR_DRAW : ofrs_pkg::SW_COPY;
    end

    ofrs_stores #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_stores (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .draw_rd_addr (pix_addr_c),
        .draw_wr_addr (pix_addr_reg),
        .draw_wr_data (draw_wr_data),
        .frame_rd_addr(AW'(s_data.read_index)),
        .draw_rd_data (draw_rd_data),
        .frame_rd_data(frame_rd_data),
        .sweep_done   (sweep_done)
    );

    ofrs_seq #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (in_exec),
        .req      (item_reg.req_type),
        .xfer     (xfer),
        .snap     (snap),
        .busy_out (busy_n),
        .avail_out(avail_n),
        .pend_out (pend_n)
    );

    // result of the item in hand
    always_comb begin
        res_c.start_transfer  = xfer.start;
        res_c.transfer_kind   = xfer.kind;
        res_c.transfer_page   = xfer.page;
        res_c.transfer_length = xfer.length;
        res_c.lead_byte       = xfer.lead;
        res_c.page_command    = xfer.cmd;
        res_c.read_data       = ((item_reg.req_type == ofrs_pkg::REQ_READ) && rd_ok_reg) ?
                                frame_rd_data : 8'h00;
        res_c.busy_res        = busy_n;
        res_c.available       = avail_n;
        res_c.pending         = pend_n;
    end

    assign load_out = ((in_exec && !need_sweep) || (state_reg == ST_HOLD)) && out_free;

    // item control
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (need_sweep) begin
                    state_next = ST_SWEEP;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_SWEEP: begin
                if (sweep_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result holding and output registers
    always_ff @(posedge aclk) begin
        if (in_exec && !load_out) begin
            res_reg <= res_c;
        end
        if (load_out) begin
            m_data_reg <= in_exec ? res_c : res_reg;
        end
    end

    // an accepted request is worked on in the very next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed next cycle");

    // the sweep ends only while the item logic waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_done |-> (state_reg == ST_SWEEP || state_reg == ST_INIT))
        else $error("sweep finished outside a sweep wait");

    // a new result only ever comes from execution or the hold register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC || state_reg == ST_HOLD))
        else $error("result raised from an unexpected state");

endmodule

### rtl/ofrs_stores.sv
// ----------------------------------------------------------------------------
// ofrs_stores
// Draw and frame byte stores with a sweep engine for clear, snapshot copy
// and the clearing pass after reset.
// ----------------------------------------------------------------------------
module ofrs_stores #(
    parameter int unsigned COLUMNS = 128,
    parameter int unsigned PAGES   = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ofrs_pkg::store_ctl_t                 ctl,
    input  logic [$clog2(COLUMNS*PAGES)-1:0]     draw_rd_addr,
    input  logic [$clog2(COLUMNS*PAGES)-1:0]     draw_wr_addr,
    input  logic [7:0]                           draw_wr_data,
    input  logic [$clog2(COLUMNS*PAGES)-1:0]     frame_rd_addr,
    output logic [7:0]                           draw_rd_data,
    output logic [7:0]                           frame_rd_data,
    output logic                                 sweep_done
);

    localparam int unsigned N  = COLUMNS * PAGES;
    localparam int unsigned AW = $clog2(N);
    localparam logic [AW-1:0] LAST_ADDR = AW'(N - 1);

    logic [7:0] draw_mem  [N];
    logic [7:0] frame_mem [N];

    // sweep issue stage and write-back stage
    logic                  sw_act_reg, sw_act_next;
    logic [AW-1:0]         sw_addr_reg, sw_addr_next;
    ofrs_pkg::sweep_mode_t sw_mode_reg, sw_mode_next;
    logic                  wb_act_reg, wb_act_next;
    logic [AW-1:0]         wb_addr_reg, wb_addr_next;
    logic                  wb_last_reg, wb_last_next;

    logic          d_re, d_we, f_we;
    logic [AW-1:0] d_ra, d_wa;
    logic [7:0]    d_wd, f_wd;

    // sweep sequencing
    always_comb begin
        sw_act_next  = sw_act_reg;
        sw_addr_next = sw_addr_reg;
        sw_mode_next = sw_mode_reg;
        wb_act_next  = sw_act_reg;
        wb_addr_next = sw_addr_reg;
        wb_last_next = (sw_addr_reg == LAST_ADDR);
        if (sw_act_reg) begin
            if (sw_addr_reg == LAST_ADDR) begin
                sw_act_next = 1'b0;
            end else begin
                sw_addr_next = sw_addr_reg + 1'b1;
            end
        end else if (ctl.sweep_start) begin
            sw_act_next  = 1'b1;
            sw_addr_next = '0;
            sw_mode_next = ctl.sweep_mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_act_reg  <= 1'b1;
            sw_addr_reg <= '0;
            sw_mode_reg <= ofrs_pkg::SW_CLEAR_ALL;
            wb_act_reg  <= 1'b0;
            wb_addr_reg <= '0;
            wb_last_reg <= 1'b0;
        end else begin
            sw_act_reg  <= sw_act_next;
            sw_addr_reg <= sw_addr_next;
            sw_mode_reg <= sw_mode_next;
            wb_act_reg  <= wb_act_next;
            wb_addr_reg <= wb_addr_next;
            wb_last_reg <= wb_last_next;
        end
    end

    assign sweep_done = wb_act_reg && wb_last_reg;

    // port selection: the sweep owns the ports while it runs
    always_comb begin
        d_re = sw_act_reg || ctl.rd_draw;
        d_ra = sw_act_reg ? sw_addr_reg : draw_rd_addr;
        d_we = 1'b0;
        d_wa = draw_wr_addr;
        d_wd = draw_wr_data;
        f_we = 1'b0;
        f_wd = '0;
        if (wb_act_reg) begin
            d_we = (sw_mode_reg != ofrs_pkg::SW_COPY);
            d_wa = wb_addr_reg;
            d_wd = '0;
            f_we = (sw_mode_reg != ofrs_pkg::SW_CLEAR_DRAW);
            f_wd = (sw_mode_reg == ofrs_pkg::SW_COPY) ? draw_rd_data : 8'h00;
        end else if (ctl.wr_draw) begin
            d_we = 1'b1;
        end
    end

    // draw store
    always_ff @(posedge aclk) begin
        if (d_we) begin
            draw_mem[d_wa] <= d_wd;
        end
        if (d_re) begin
            draw_rd_data <= draw_mem[d_ra];
        end
    end

    // frame store
    always_ff @(posedge aclk) begin
        if (f_we) begin
            frame_mem[wb_addr_reg] <= f_wd;
        end
        if (ctl.rd_frame) begin
            frame_rd_data <= frame_mem[frame_rd_addr];
        end
    end

endmodule

### rtl/ofrs_seq.sv
// ----------------------------------------------------------------------------
// ofrs_seq
// Refresh sequencer: page command and data transfer ordering, busy,
// pending and available flags.
// ----------------------------------------------------------------------------
module ofrs_seq #(
    parameter int unsigned COLUMNS = 128,
    parameter int unsigned PAGES   = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [2:0]            req,
    output ofrs_pkg::xfer_t       xfer,
    output logic                  snap,
    output logic                  busy_out,
    output logic                  avail_out,
    output logic                  pend_out
);

    localparam int unsigned PW = $clog2(PAGES + 1);
    localparam logic [7:0] DATA_LEN = 8'((COLUMNS + 1) % 256);
    localparam logic [PW-1:0] PAGE_END = PW'(PAGES);

    typedef enum logic [2:0] {
        STG_IDLE = 3'b001,
        STG_CMD  = 3'b010,
        STG_DATA = 3'b100
    } stage_t;

    stage_t        stage_reg, stage_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic          busy_reg, busy_next;
    logic          pend_reg, pend_next;
    logic          avail_reg, avail_next;
    logic [PW-1:0] pc_inc;

    assign pc_inc = pc_reg + 1'b1;

    // next state of the sequencer for the item in hand
    always_comb begin
        stage_next = stage_reg;
        pc_next    = pc_reg;
        busy_next  = busy_reg;
        pend_next  = pend_reg;
        avail_next = avail_reg;
        xfer       = '0;
        snap       = 1'b0;
        unique case (req)
            ofrs_pkg::REQ_UPDATE: begin
                if (avail_reg) begin
                    if (busy_reg) begin
                        pend_next = 1'b1;
                    end else begin
                        snap       = 1'b1;
                        pend_next  = 1'b0;
                        busy_next  = 1'b1;
                        pc_next    = '0;
                        stage_next = STG_CMD;
                        xfer = ofrs_pkg::make_xfer(ofrs_pkg::KIND_CMD, 8'h00, DATA_LEN);
                    end
                end
            end
            ofrs_pkg::REQ_DONE: begin
                unique case (stage_reg)
                    STG_CMD: begin
                        stage_next = STG_DATA;
                        xfer = ofrs_pkg::make_xfer(ofrs_pkg::KIND_DATA, 8'(pc_reg),
                                                   DATA_LEN);
                    end
                    STG_DATA: begin
                        pc_next = pc_inc;
                        if (pc_inc < PAGE_END) begin
                            stage_next = STG_CMD;
                            xfer = ofrs_pkg::make_xfer(ofrs_pkg::KIND_CMD, 8'(pc_inc),
                                                       DATA_LEN);
                        end else begin
                            stage_next = STG_IDLE;
                            busy_next  = 1'b0;
                            // held request starts the next frame at once
                            if (pend_reg) begin
                                snap       = 1'b1;
                                pend_next  = 1'b0;
                                busy_next  = 1'b1;
                                pc_next    = '0;
                                stage_next = STG_CMD;
                                xfer = ofrs_pkg::make_xfer(ofrs_pkg::KIND_CMD, 8'h00,
                                                           DATA_LEN);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ofrs_pkg::REQ_ERROR: begin
                stage_next = STG_IDLE;
                busy_next  = 1'b0;
                avail_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign busy_out  = busy_next;
    assign avail_out = avail_next;
    assign pend_out  = pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= STG_IDLE;
            pc_reg    <= '0;
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            avail_reg <= 1'b1;
        end else if (step) begin
            stage_reg <= stage_next;
            pc_reg    <= pc_next;
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
            avail_reg <= avail_next;
        end
    end

endmodule
